// ===== src/frame_payload_pattern_match_defines.svh =====
// Assertion macros shared by the frame payload pattern filter.
`ifndef FRAME_PAYLOAD_PATTERN_MATCH_DEFINES_SVH
`define FRAME_PAYLOAD_PATTERN_MATCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FPPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FPPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define FPPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/fppm_pkg.sv =====
// Constants, types and helpers of the frame payload pattern filter.
package fppm_pkg;

  localparam int unsigned PATTERN_MAX = 16;
  localparam int unsigned WIN_IDX_W   = $clog2(PATTERN_MAX);
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned FLEN_W      = POS_W + 1;

  localparam logic [7:0] ETH_HEADER_BYTES  = 8'd14;
  localparam logic [7:0] ICMP_HEADER_BYTES = 8'd8;
  localparam logic [7:0] UDP_HEADER_BYTES  = 8'd8;

  // Ether type of ARP, split into its two bytes
  localparam logic [7:0] KIND_ARP_HI = 8'h08;
  localparam logic [7:0] KIND_ARP_LO = 8'h06;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Byte positions within the frame
  localparam logic [POS_W-1:0] POS_KIND_HI = 8'd12;
  localparam logic [POS_W-1:0] POS_KIND_LO = 8'd13;
  localparam logic [POS_W-1:0] POS_IHL     = 8'd14;
  localparam logic [POS_W-1:0] POS_PROTO   = 8'd23;
  // TCP data offset sits at 26 + IP header length
  localparam logic [FLEN_W-1:0] TCP_OFS_BASE = 9'd26;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAT_LO  = 2'd0;
  localparam logic [1:0] CFG_PAT_HI  = 2'd1;
  localparam logic [1:0] CFG_PAT_LEN = 2'd2;

  // Header parser view for the current word
  typedef struct packed {
    logic [POS_W-1:0] pos;       // position of this word (saturating)
    logic [7:0]       total;     // header length including this word
    logic             is_short;  // frame would be short if it ended here
  } hdr_info_t;

  function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
                                              input logic [63:0] hi,
                                              input logic [WIN_IDX_W-1:0] idx);
    logic [63:0] w;
    w = idx[WIN_IDX_W-1] ? hi : lo;
    return w[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage

// ===== src/fppm_cell.sv =====
// One window cell: holds a frame byte and compares it with its pattern byte.
module fppm_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);
  logic [7:0] byte_q;

  // compare the byte about to be held; idle cells never veto
  assign hit_o  = !active_i || (byte_i == pat_byte_i);
  assign byte_o = byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end
endmodule

// ===== src/fppm_hdr.sv =====
// Header parser: tracks frame position and where the payload starts.
module fppm_hdr (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  input  logic                  last_i,
  output fppm_pkg::hdr_info_t   info_o
);
  import fppm_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [7:0]        kind_hi_q, kind_hi_d;
  logic              arp_q, arp_d;
  logic [5:0]        ihl_q, ihl_d;
  logic [7:0]        proto_q, proto_d;
  logic [7:0]        total_q, total_d;
  logic [FLEN_W-1:0] flen;
  logic              tcp_ofs_pos;

  assign flen        = {1'b0, pos_q} + FLEN_W'(1);
  assign tcp_ofs_pos = (pos_q > POS_PROTO) && (proto_q == PROTO_TCP) &&
                       ({1'b0, pos_q} == TCP_OFS_BASE + FLEN_W'(ihl_q));

  always_comb begin
    kind_hi_d = kind_hi_q;
    arp_d     = arp_q;
    ihl_d     = ihl_q;
    proto_d   = proto_q;
    total_d   = total_q;
    if (pos_q == POS_KIND_HI) begin
      kind_hi_d = byte_i;
    end else if (pos_q == POS_KIND_LO) begin
      arp_d = (kind_hi_q == KIND_ARP_HI) && (byte_i == KIND_ARP_LO);
    end else if (!arp_q && pos_q == POS_IHL) begin
      ihl_d   = {byte_i[3:0], 2'b00};
      total_d = ETH_HEADER_BYTES + 8'({byte_i[3:0], 2'b00});
    end else if (!arp_q && pos_q == POS_PROTO) begin
      proto_d = byte_i;
      if (byte_i == PROTO_ICMP) begin
        total_d = total_q + ICMP_HEADER_BYTES;
      end else if (byte_i == PROTO_UDP) begin
        total_d = total_q + UDP_HEADER_BYTES;
      end
    end else if (!arp_q && tcp_ofs_pos) begin
      total_d = total_q + 8'({byte_i[7:4], 2'b00});
    end
  end

  assign pos_d = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

  assign info_o.pos      = pos_q;
  assign info_o.total    = total_d;
  assign info_o.is_short =
      (flen < FLEN_W'(ETH_HEADER_BYTES)) ||
      (!arp_d && flen < FLEN_W'(POS_PROTO) + FLEN_W'(1)) ||
      (!arp_d && proto_d == PROTO_TCP &&
       flen < TCP_OFS_BASE + FLEN_W'(1) + FLEN_W'(ihl_d)) ||
      (flen < FLEN_W'(total_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      kind_hi_q <= '0;
      arp_q     <= 1'b0;
      ihl_q     <= '0;
      proto_q   <= '0;
      total_q   <= ETH_HEADER_BYTES;
    end else if (accept_i) begin
      if (last_i) begin
        pos_q     <= '0;
        kind_hi_q <= '0;
        arp_q     <= 1'b0;
        ihl_q     <= '0;
        proto_q   <= '0;
        total_q   <= ETH_HEADER_BYTES;
      end else begin
        pos_q     <= pos_d;
        kind_hi_q <= kind_hi_d;
        arp_q     <= arp_d;
        ihl_q     <= ihl_d;
        proto_q   <= proto_d;
        total_q   <= total_d;
      end
    end
  end
endmodule

// ===== src/frame_payload_pattern_match.sv =====
// Frame payload pattern filter: top level with window chain and result register.
//
// Takes an Ethernet frame one byte word per cycle and, on the word marked
// end_of_frame_i, delivers one result word: whether the configured pattern
// (1 to 16 bytes, length 0 turns the filter off) lies wholly inside the
// payload, the payload offset, and whether the frame ended inside its own
// headers. Payload start is 14 for ARP, else 14 + IHL*4 plus 8 for ICMP,
// 8 for UDP or the TCP data offset*4. Throughput is one word per cycle;
// the pattern window is a chain of 16 byte cells, each comparing the byte
// it is about to take against its own pattern byte, so a hit is known in
// the cycle the byte arrives. The result sits in an output register from
// the cycle after the last word. Input stall rises only when a last word meets
// a result still held by a stalled output; other words keep flowing.
// Pattern registers may be rewritten between words and apply from the
// next word.
module frame_payload_pattern_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // frame byte words in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        end_of_frame_i,
  // result words out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_passes_o,
  output logic [7:0]  payload_offset_o,
  output logic        frame_short_o
);
  import fppm_pkg::*;

  // configuration
  logic [63:0]      pat_lo_q, pat_hi_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [LEN_W-1:0] len_eff;

  // handshake
  logic in_acc, out_acc, out_valid_q;

  // header parser
  hdr_info_t hdr;

  // window chain
  logic [7:0] cell_in  [PATTERN_MAX];
  logic [7:0] cell_out [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  // match tracking
  logic [FLEN_W-1:0] flen;
  logic [FLEN_W-1:0] start_now;
  logic              hit;
  logic              seen_q, seen_d;
  logic [FLEN_W-1:0] start_q, start_d;
  logic              pass;

  // result register
  logic       passes_q, short_q;
  logic [7:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LO:  pat_lo_q  <= cfg_data_i;
        CFG_PAT_HI:  pat_hi_q  <= cfg_data_i;
        CFG_PAT_LEN: pat_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // lengths above the window act as a full window
  assign len_eff = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;

  // a last word waits only while a held result is stalled
  assign in_stall_o = out_valid_q && out_stall_i && end_of_frame_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  fppm_hdr u_hdr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (frame_byte_i),
    .last_i   (end_of_frame_i),
    .info_o   (hdr)
  );

  // cell k holds the byte k words back; it checks pattern byte len-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [LEN_W-1:0] pat_idx;
    assign pat_idx = len_eff - LEN_W'(1) - LEN_W'(k);
    if (k == 0) begin : g_head
      assign cell_in[k] = frame_byte_i;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    fppm_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (in_acc),
      .byte_i     (cell_in[k]),
      .pat_byte_i (pattern_byte(pat_lo_q, pat_hi_q, pat_idx[WIN_IDX_W-1:0])),
      .active_i   (LEN_W'(k) < len_eff),
      .byte_o     (cell_out[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // the whole pattern must fit in the bytes seen so far in this frame
  assign flen      = {1'b0, hdr.pos} + FLEN_W'(1);
  assign start_now = flen - FLEN_W'(len_eff);
  assign hit       = (&cell_hit) && (len_eff != '0) && (flen >= FLEN_W'(len_eff));
  assign seen_d    = seen_q || hit;
  assign start_d   = hit ? start_now : start_q;

  // a match counts only if it starts at or after the final header length
  assign pass = (len_eff == '0) ||
                (!hdr.is_short && seen_d && start_d >= FLEN_W'(hdr.total));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= 1'b0;
      start_q <= '0;
    end else if (in_acc) begin
      if (end_of_frame_i) begin
        seen_q  <= 1'b0;
        start_q <= '0;
      end else begin
        seen_q  <= seen_d;
        start_q <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && end_of_frame_i) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && end_of_frame_i) begin
      passes_q <= pass;
      offset_q <= hdr.total;
      short_q  <= hdr.is_short;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_passes_o   = passes_q;
  assign payload_offset_o = offset_q;
  assign frame_short_o    = short_q;

`include "frame_payload_pattern_match_defines.svh"

  `FPPM_ASSERT_NEXT(a_last_gives_result, in_acc && end_of_frame_i, out_valid_o, "last word gave no result")
  `FPPM_ASSERT_NEXT(a_no_spurious_result, in_acc && !end_of_frame_i && !out_valid_q, !out_valid_o, "result without last word")
  `FPPM_ASSERT_IMPL(a_header_floor, 1'b1, hdr.total >= ETH_HEADER_BYTES, "header shorter than Ethernet header")

endmodule
